// ----- design/sfr_pkg.sv -----
package sfr_pkg;

  localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND  = 8'hCC;
  localparam logic [7:0]  TRAILER_BYTE = 8'h55;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_CRC_ERR     = 2'd1,
    STATUS_TRAILER_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    status_t    frame_status;
    logic [7:0] payload_length;
  } result_t;

  // crc-16/modbus, one byte, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ----- design/sfr_if.sv -----
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       frame_done;
  logic [1:0] frame_status;
  logic [7:0] payload_length;

  modport source (output valid, output payload_byte, output payload_valid, output frame_done,
                  output frame_status, output payload_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid, input frame_done,
                  input frame_status, input payload_length, output ready);
endinterface

// ----- design/sfr_parser.sv -----
module sfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output sfr_pkg::result_t    result
);

  typedef enum logic [2:0] {
    HUNT1 = 3'd0,
    HUNT2 = 3'd1,
    LEN   = 3'd2,
    PAY   = 3'd3,
    CRCLO = 3'd4,
    CRCHI = 3'd5,
    TRAIL = 3'd6
  } stage_t;

  stage_t      stage, stage_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [7:0]  crc_high, crc_high_next;
  logic [15:0] crc_fed;

  assign crc_fed = sfr_pkg::crc_feed(crc, rx_byte);

  always_comb begin
    stage_next        = stage;
    frame_length_next = frame_length;
    bytes_left_next   = bytes_left;
    crc_next          = crc;
    crc_low_next      = crc_low;
    crc_high_next     = crc_high;
    result            = '0;
    unique case (stage)
      HUNT2: begin
        if (rx_byte == sfr_pkg::SYNC_SECOND) begin
          crc_next   = crc_fed;
          stage_next = LEN;
        end else begin
          crc_next   = sfr_pkg::CRC_INIT;
          stage_next = HUNT1;
        end
      end
      LEN: begin
        frame_length_next = rx_byte;
        bytes_left_next   = rx_byte;
        crc_next          = crc_fed;
        stage_next        = (rx_byte == 8'd0) ? CRCLO : PAY;
      end
      PAY: begin
        result.payload_byte  = rx_byte;
        result.payload_valid = 1'b1;
        crc_next             = crc_fed;
        bytes_left_next      = bytes_left - 8'd1;
        if (bytes_left == 8'd1) stage_next = CRCLO;
      end
      CRCLO: begin
        crc_low_next = rx_byte;
        stage_next   = CRCHI;
      end
      CRCHI: begin
        crc_high_next = rx_byte;
        stage_next    = TRAIL;
      end
      TRAIL: begin
        result.frame_done     = 1'b1;
        result.payload_length = frame_length;
        if (rx_byte != sfr_pkg::TRAILER_BYTE) result.frame_status = sfr_pkg::STATUS_TRAILER_ERR;
        else if ({crc_high, crc_low} != crc) result.frame_status = sfr_pkg::STATUS_CRC_ERR;
        else result.frame_status = sfr_pkg::STATUS_OK;
        stage_next      = HUNT1;
        crc_next        = sfr_pkg::CRC_INIT;
        bytes_left_next = 8'd0;
      end
      default: begin
        // hunting, also covers the unused stage code
        if (rx_byte == sfr_pkg::SYNC_FIRST) begin
          crc_next   = sfr_pkg::crc_feed(sfr_pkg::CRC_INIT, rx_byte);
          stage_next = HUNT2;
        end else begin
          crc_next   = sfr_pkg::CRC_INIT;
          stage_next = HUNT1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= HUNT1;
      frame_length <= 8'd0;
      bytes_left   <= 8'd0;
      crc          <= sfr_pkg::CRC_INIT;
      crc_low      <= 8'd0;
      crc_high     <= 8'd0;
    end else if (accept) begin
      stage        <= stage_next;
      frame_length <= frame_length_next;
      bytes_left   <= bytes_left_next;
      crc          <= crc_next;
      crc_low      <= crc_low_next;
      crc_high     <= crc_high_next;
    end
  end

endmodule

// ----- design/serial_frame_receiver_crc16.sv -----
// output: a result is registered and appears in the cycle after its byte transfer
// throughput: one byte per cycle unless out_ch stalls; the parser and crc update
// finish in that cycle; the output register is reloaded whenever empty or being taken
// reset (rst, synchronous): parser hunts for the first sync byte, crc back to
// 0xffff, output register empty
module serial_frame_receiver_crc16 (
  input logic       clk,
  input logic       rst,
  sfr_in_if.sink    in_ch,
  sfr_out_if.source out_ch
);

  sfr_pkg::result_t res_comb;
  sfr_pkg::result_t res_q;
  logic             res_valid;
  logic             accept;

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .result  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_ch.ready) begin
      res_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res_comb;
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.payload_byte   = res_q.payload_byte;
  assign out_ch.payload_valid  = res_q.payload_valid;
  assign out_ch.frame_done     = res_q.frame_done;
  assign out_ch.frame_status   = res_q.frame_status;
  assign out_ch.payload_length = res_q.payload_length;

endmodule

// ----- design/sfr_checker.sv -----
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       payload_valid,
  input logic       frame_done,
  input logic [1:0] frame_status,
  input logic [7:0] payload_length
);

  // output register empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a byte is either payload or trailer, never both
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(payload_valid && frame_done))
    else $error("payload and frame done together");

  // status and length only carry meaning at frame done
  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (frame_status == 2'd0 && payload_length == 8'd0))
    else $error("status or length set outside frame done");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(frame_status) && $stable(frame_done)))
    else $error("stalled result changed");

endmodule

bind serial_frame_receiver_crc16 sfr_checker u_sfr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_valid  (out_ch.payload_valid),
  .frame_done     (out_ch.frame_done),
  .frame_status   (out_ch.frame_status),
  .payload_length (out_ch.payload_length)
);

// ----- tb/sv/serial_frame_receiver_crc16_test.sv -----
module serial_frame_receiver_crc16_test;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_BYTES = 120;
  localparam sfr_pkg::result_t NO_RESULT = '{8'h00, 1'b0, 1'b0, sfr_pkg::STATUS_OK, 8'h00};

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_LENGTH, GET_PAYLOAD, GET_CRC_LO, GET_CRC_HI, GET_TRAILER
  } parse_stage_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_LO_BAD, ROW_CRC_HI} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [7:0]       value;
    bit               typed;
    sfr_pkg::result_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  serial_frame_receiver_crc16 u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the deframer state
  parse_stage_t stage     = HUNT_FIRST;
  logic [7:0]   frame_len = 8'h00;
  logic [7:0]   left      = 8'h00;
  logic [15:0]  crc_acc   = sfr_pkg::CRC_INIT;
  logic [7:0]   crc_lo    = 8'h00;
  logic [7:0]   crc_hi    = 8'h00;

  sfr_pkg::result_t frame_outputs_due [$];
  dir_row_t    directed_rows [25];
  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned payload_seen  = 0;
  int unsigned frames_ok     = 0;
  int unsigned frames_crc    = 0;
  int unsigned frames_trail  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_active   = 1'b0;
  event        hold_off_ev;

  // bitwise form: each input bit is folded into the feedback term
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ sfr_pkg::CRC_POLY;
    end
    return acc;
  endfunction

  function automatic sfr_pkg::result_t deframe_byte(input logic [7:0] b);
    sfr_pkg::result_t r;
    r = NO_RESULT;
    case (stage)
      HUNT_SECOND: begin
        if (b == sfr_pkg::SYNC_SECOND) begin
          crc_acc = modbus_crc_byte(crc_acc, b);
          stage   = GET_LENGTH;
        end else begin
          stage   = HUNT_FIRST;
          crc_acc = sfr_pkg::CRC_INIT;
        end
      end
      GET_LENGTH: begin
        frame_len = b;
        left      = b;
        crc_acc   = modbus_crc_byte(crc_acc, b);
        stage     = (b == 8'h00) ? GET_CRC_LO : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        crc_acc         = modbus_crc_byte(crc_acc, b);
        left            = left - 8'd1;
        if (left == 8'h00) stage = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        crc_lo = b;
        stage  = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        crc_hi = b;
        stage  = GET_TRAILER;
      end
      GET_TRAILER: begin
        r.frame_done     = 1'b1;
        r.payload_length = frame_len;
        // a bad trailer wins over a crc mismatch
        if (b != sfr_pkg::TRAILER_BYTE) r.frame_status = sfr_pkg::STATUS_TRAILER_ERR;
        else if ({crc_hi, crc_lo} != crc_acc) r.frame_status = sfr_pkg::STATUS_CRC_ERR;
        else r.frame_status = sfr_pkg::STATUS_OK;
        stage   = HUNT_FIRST;
        crc_acc = sfr_pkg::CRC_INIT;
        left    = 8'h00;
      end
      default: begin
        stage   = HUNT_FIRST;
        crc_acc = sfr_pkg::CRC_INIT;
        if (b == sfr_pkg::SYNC_FIRST) begin
          crc_acc = modbus_crc_byte(sfr_pkg::CRC_INIT, b);
          stage   = HUNT_SECOND;
        end
      end
    endcase
    return r;
  endfunction

  // offers one byte, waits for the transfer, and leaves at the next falling edge
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input sfr_pkg::result_t typed_res);
    sfr_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    r = deframe_byte(b);
    if (typed) r = typed_res;
    frame_outputs_due = {frame_outputs_due, r};
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len_req);
    int unsigned len;
    int unsigned pick;
    logic [7:0]  lo;
    logic [7:0]  hi;
    pick = $urandom_range(99);
    if (len_req >= 0) len = len_req;
    else if (pick < 70) len = $urandom_range(0, 6);
    else len = $urandom_range(7, 40);
    send_byte(sfr_pkg::SYNC_FIRST, 1'b0, NO_RESULT);
    send_byte(sfr_pkg::SYNC_SECOND, 1'b0, NO_RESULT);
    send_byte(len[7:0], 1'b0, NO_RESULT);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
    lo = crc_acc[7:0];
    hi = crc_acc[15:8];
    pick = $urandom_range(99);
    if (pick < 6) lo = lo ^ (8'h01 << $urandom_range(7));
    else if (pick < 12) hi = hi ^ (8'h01 << $urandom_range(7));
    send_byte(lo, 1'b0, NO_RESULT);
    send_byte(hi, 1'b0, NO_RESULT);
    send_byte(($urandom_range(99) < 90) ? sfr_pkg::TRAILER_BYTE : 8'($urandom_range(255)),
              1'b0, NO_RESULT);
  endtask

  // line noise and sync patterns that break off
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    if ($urandom_range(1) == 1) begin
      send_byte(sfr_pkg::SYNC_FIRST, 1'b0, NO_RESULT);
      send_byte(($urandom_range(1) == 1) ? sfr_pkg::SYNC_FIRST : 8'($urandom_range(255)),
                1'b0, NO_RESULT);
    end
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
  endtask

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long hold-off of the output side, counted here
  initial begin
    forever begin
      @(hold_off_ev);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  always @(posedge clk) begin
    sfr_pkg::result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (frame_outputs_due.size() == 0) begin
        $display("%0t: unexpected result: byte %0h valid %0b done %0b status %0d len %0h",
                 $time, out_ch.payload_byte, out_ch.payload_valid, out_ch.frame_done,
                 out_ch.frame_status, out_ch.payload_length);
        errors++;
      end else begin
        want = frame_outputs_due.pop_front();
        if (out_ch.payload_byte !== want.payload_byte)
          report("payload_byte", want.payload_byte, out_ch.payload_byte);
        if (out_ch.payload_valid !== want.payload_valid)
          report("payload_valid", want.payload_valid, out_ch.payload_valid);
        if (out_ch.frame_done !== want.frame_done)
          report("frame_done", want.frame_done, out_ch.frame_done);
        if (out_ch.frame_status !== want.frame_status)
          report("frame_status", want.frame_status, out_ch.frame_status);
        if (out_ch.payload_length !== want.payload_length)
          report("payload_length", want.payload_length, out_ch.payload_length);
        if (want.payload_valid) payload_seen++;
        if (want.frame_done) begin
          case (want.frame_status)
            sfr_pkg::STATUS_OK:      frames_ok++;
            sfr_pkg::STATUS_CRC_ERR: frames_crc++;
            default:                 frames_trail++;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, quiet, frame_outputs_due.size());
    $display("** serial_frame_receiver_crc16: FAILED **");
    $finish;
  end

  initial begin
    logic [7:0]  b;
    int unsigned phase_end;
    int unsigned idle_by_phase [4];
    int unsigned stall_by_phase [4];
    idle_by_phase  = '{0, 56, 0, 22};
    stall_by_phase = '{0, 0, 56, 22};
    directed_rows = '{
      '{ROW_BYTE,       8'h00, 1'b1, NO_RESULT},
      // wrong second sync byte, then 0xaa in the second sync position
      '{ROW_BYTE,       8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'hAA, 1'b0, NO_RESULT},
      // zero length frame, good crc
      '{ROW_BYTE,       8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'hCC, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h00, 1'b0, NO_RESULT},
      '{ROW_CRC_LO,     8'h00, 1'b0, NO_RESULT},
      '{ROW_CRC_HI,     8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h55, 1'b1, '{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_OK, 8'h00}},
      // crc mismatch
      '{ROW_BYTE,       8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'hCC, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h01, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, sfr_pkg::STATUS_OK, 8'h00}},
      '{ROW_CRC_LO_BAD, 8'h00, 1'b0, NO_RESULT},
      '{ROW_CRC_HI,     8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h55, 1'b1, '{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_CRC_ERR, 8'h01}},
      // bad trailer on top of a crc mismatch
      '{ROW_BYTE,       8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'hCC, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h01, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, sfr_pkg::STATUS_OK, 8'h00}},
      '{ROW_CRC_LO_BAD, 8'h00, 1'b0, NO_RESULT},
      '{ROW_CRC_HI,     8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE,       8'h00, 1'b1,
        '{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_TRAILER_ERR, 8'h01}}
    };

    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CRC_LO:     b = crc_acc[7:0];
        ROW_CRC_LO_BAD: b = ~crc_acc[7:0];
        ROW_CRC_HI:     b = crc_acc[15:8];
        default:        b = directed_rows[i].value;
      endcase
      send_byte(b, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      // sender keeps offering while the output side is held off
      if (phase == 0) -> hold_off_ev;
      if (phase == 3) send_frame(255);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(99) < 75) send_frame(-1);
        else send_noise();
      end
    end
    in_ch.valid <= 1'b0;

    while (frame_outputs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d input bytes in four idle/stall phases plus a long output hold-off",
             bytes_sent);
    $display("frames: %0d ok, %0d crc error, %0d trailer error; %0d payload bytes",
             frames_ok, frames_crc, frames_trail, payload_seen);
    if (errors == 0) begin
      $display("** serial_frame_receiver_crc16: PASSED **");
    end else begin
      $display("** serial_frame_receiver_crc16: FAILED **");
    end
    $finish;
  end

endmodule
